// ===== hdl/scbpa_pkg.sv =====
// shared constants, types and helpers for the size class block pool allocator
package scbpa_pkg;

    localparam int NUM_CLASSES      = 9;
    localparam int BLOCKS_PER_CLASS = 64;
    localparam int MIN_BLOCK_BYTES  = 32;
    localparam int HEAP_LIMIT       = 8192;
    localparam int FALLBACK_LIMIT   = 4096;

    localparam int SIZE_W = 16;
    localparam int CLS_W  = 4;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int ST_W   = 3;

    localparam int POOL_DEPTH = NUM_CLASSES * BLOCKS_PER_CLASS;
    localparam int ADDR_W     = $clog2(POOL_DEPTH);

    typedef enum logic [0:0] {
        KIND_ALLOC,
        KIND_FREE
    } t_kind;

    typedef enum logic [ST_W-1:0] {
        ST_ALLOC,
        ST_FREED,
        ST_ZERO,
        ST_HEAP,
        ST_EXHAUST,
        ST_DOUBLE,
        ST_BADCLASS
    } t_status;

    typedef struct packed {
        t_kind             kind;
        logic [SIZE_W-1:0] req_size;
        logic [CLS_W-1:0]  free_class;
        logic [IDX_W-1:0]  free_index;
    } t_request;

    typedef struct packed {
        t_status          status;
        logic [CLS_W-1:0] block_class;
        logic [IDX_W-1:0] pool_slot;
        logic [CNT_W-1:0] idle_left;
    } t_result;

    // classified command handed from the front end to the pool engine
    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_REPORT
    } t_op;

    typedef struct packed {
        t_op              op;
        t_status          status;
        logic [CLS_W-1:0] cls;
        logic [IDX_W-1:0] idx;
        logic             fb_ok;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_ACCESS
    } t_bk_state;

    function automatic logic [ADDR_W-1:0] pool_addr(input logic [CLS_W-1:0] cls,
                                                    input logic [IDX_W-1:0] idx);
        return ADDR_W'(cls) * ADDR_W'(BLOCKS_PER_CLASS) + ADDR_W'(idx);
    endfunction

endpackage

// ===== hdl/size_class_block_pool_allocator.sv =====
// top level of the size class block pool allocator
// Requests enter through a queue-style port: a transaction is taken when push is
// high and full is low. Each request is an allocate (size in bytes) or a free
// (class and index). Results leave through a queue-style port: the oldest result
// sits on o_res while empty is low and is taken when pop is high.
// Exactly one result comes back per request, in request order.
// A request is classified on entry and waits in a two-entry command queue.
// Allocate and free pass through the engine's idle state, which reads the link or
// used-bit memory, then its access state, which does the update; the engine takes
// no new command while in access. Size-zero, too-large, exhausted and invalid-class
// requests are answered from idle. The engine writes each result into the result
// queue, and it holds in idle, taking no command, while that queue is full.
// After reset the engine sweeps both 576-entry pool memories, one entry a cycle,
// and full is high for the whole sweep; all pools then start full and in order.
// When the receiver stops popping, the two-entry result queue fills, the engine
// halts, the command queue fills and full rises; nothing is dropped.
module size_class_block_pool_allocator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  scbpa_pkg::t_request i_req,
    output logic                empty,
    input  logic                pop,
    output scbpa_pkg::t_result  o_res
);

    logic               cmd_valid;
    scbpa_pkg::t_cmd    cmd;
    logic               cmd_pop;
    logic               busy;
    logic               out_full;
    logic               res_push;
    scbpa_pkg::t_result res;

    scbpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_req       (i_req),
        .i_busy      (busy),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    scbpa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_busy      (busy),
        .i_out_full  (out_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    scbpa_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_push (res_push),
        .i_res      (res),
        .o_q_full   (out_full),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_res      (o_res)
    );

endmodule

// ===== hdl/scbpa_ram.sv =====
// generic single write port, single read port ram with registered read data
module scbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/scbpa_front.sv =====
// request front end: classifies requests and queues them for the pool engine
module scbpa_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  scbpa_pkg::t_request i_req,
    input  logic                i_busy,
    output logic                o_cmd_valid,
    output scbpa_pkg::t_cmd     o_cmd,
    input  logic                i_cmd_pop
);

    scbpa_pkg::t_cmd                r_q [2];
    logic                           r_wptr;
    logic                           r_rptr;
    logic [1:0]                     r_cnt;
    scbpa_pkg::t_cmd                n_cmd;
    logic [scbpa_pkg::CLS_W-1:0]    first_cls;
    logic                           found;
    logic                           do_push;
    logic                           do_pop;

    // smallest class whose block size holds the request
    always_comb begin
        first_cls = '0;
        found     = 1'b0;
        for (int c = scbpa_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
            if ((32'(scbpa_pkg::MIN_BLOCK_BYTES) << c) >= 32'(i_req.req_size)) begin
                first_cls = scbpa_pkg::CLS_W'(c);
                found     = 1'b1;
            end
        end
    end

    always_comb begin
        n_cmd        = '0;
        n_cmd.op     = scbpa_pkg::OP_REPORT;
        n_cmd.status = scbpa_pkg::ST_ZERO;
        if (i_req.kind == scbpa_pkg::KIND_FREE) begin
            n_cmd.cls = i_req.free_class;
            n_cmd.idx = i_req.free_index;
            if (32'(i_req.free_class) >= 32'(scbpa_pkg::NUM_CLASSES) ||
                32'(i_req.free_index) >= 32'(scbpa_pkg::BLOCKS_PER_CLASS)) begin
                n_cmd.status = scbpa_pkg::ST_BADCLASS;
            end else begin
                n_cmd.op = scbpa_pkg::OP_FREE;
            end
        end else if (i_req.req_size == '0) begin
            n_cmd.status = scbpa_pkg::ST_ZERO;
        end else if (32'(i_req.req_size) > 32'(scbpa_pkg::HEAP_LIMIT)) begin
            n_cmd.status = scbpa_pkg::ST_HEAP;
        end else if (!found) begin
            n_cmd.status = scbpa_pkg::ST_EXHAUST;
        end else begin
            n_cmd.op    = scbpa_pkg::OP_ALLOC;
            n_cmd.cls   = first_cls;
            n_cmd.fb_ok = (32'(i_req.req_size) <= 32'(scbpa_pkg::FALLBACK_LIMIT)) &&
                          (32'(first_cls) + 32'd1 < 32'(scbpa_pkg::NUM_CLASSES));
        end
    end

    assign o_full      = (r_cnt == 2'd2) || i_busy;
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wptr] <= n_cmd;
        end
    end

endmodule

// ===== hdl/scbpa_back.sv =====
// pool engine: free lists, link and used-bit memories, clearing pass after reset
module scbpa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  scbpa_pkg::t_cmd    i_cmd,
    output logic               o_cmd_pop,
    output logic               o_busy,
    input  logic               i_out_full,
    output logic               o_res_push,
    output scbpa_pkg::t_result o_res
);

    localparam int NC = scbpa_pkg::NUM_CLASSES;

    scbpa_pkg::t_bk_state         r_state, n_state;
    logic [scbpa_pkg::ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [scbpa_pkg::IDX_W-1:0]  r_clr_idx, n_clr_idx;
    logic [scbpa_pkg::IDX_W-1:0]  r_head [NC];
    logic [scbpa_pkg::IDX_W-1:0]  n_head [NC];
    logic [scbpa_pkg::IDX_W-1:0]  r_tail [NC];
    logic [scbpa_pkg::IDX_W-1:0]  n_tail [NC];
    logic [scbpa_pkg::CNT_W-1:0]  r_count [NC];
    logic [scbpa_pkg::CNT_W-1:0]  n_count [NC];
    logic [NC-1:0]                r_nonempty, n_nonempty;
    logic [NC-1:0]                nonempty_up;
    scbpa_pkg::t_op               r_op, n_op;
    logic [scbpa_pkg::CLS_W-1:0]  r_cls, n_cls;
    logic [scbpa_pkg::IDX_W-1:0]  r_idx, n_idx;

    logic [scbpa_pkg::CLS_W-1:0]  chosen;
    logic                         have_class;
    logic [scbpa_pkg::CNT_W-1:0]  cnt_new;

    logic                         link_we;
    logic [scbpa_pkg::ADDR_W-1:0] link_waddr;
    logic [scbpa_pkg::IDX_W-1:0]  link_wdata;
    logic [scbpa_pkg::ADDR_W-1:0] link_raddr;
    logic [scbpa_pkg::IDX_W-1:0]  link_rdata;
    logic                         used_we;
    logic [scbpa_pkg::ADDR_W-1:0] used_waddr;
    logic [0:0]                   used_wdata;
    logic [scbpa_pkg::ADDR_W-1:0] used_raddr;
    logic [0:0]                   used_rdata;

    scbpa_ram #(
        .WIDTH (scbpa_pkg::IDX_W),
        .DEPTH (scbpa_pkg::POOL_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    scbpa_ram #(
        .WIDTH (1),
        .DEPTH (scbpa_pkg::POOL_DEPTH)
    ) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_waddr),
        .i_wdata (used_wdata),
        .i_raddr (used_raddr),
        .o_rdata (used_rdata)
    );

    // bit c tells whether class c + 1 has a free block
    assign nonempty_up = r_nonempty >> 1;
    assign o_busy      = (r_state == scbpa_pkg::BK_CLEAR);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_clr_idx   = r_clr_idx;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_nonempty  = r_nonempty;
        n_op        = r_op;
        n_cls       = r_cls;
        n_idx       = r_idx;
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res       = '0;
        chosen      = i_cmd.cls;
        have_class  = 1'b0;
        cnt_new     = '0;
        link_we     = 1'b0;
        link_waddr  = '0;
        link_wdata  = '0;
        link_raddr  = '0;
        used_we     = 1'b0;
        used_waddr  = '0;
        used_wdata  = 1'b0;
        used_raddr  = '0;

        case (r_state)
            scbpa_pkg::BK_CLEAR: begin
                link_we    = 1'b1;
                link_waddr = r_clr_addr;
                link_wdata = (32'(r_clr_idx) == scbpa_pkg::BLOCKS_PER_CLASS - 1) ?
                             '0 : r_clr_idx + 1'b1;
                used_we    = 1'b1;
                used_waddr = r_clr_addr;
                used_wdata = 1'b0;
                n_clr_addr = r_clr_addr + 1'b1;
                n_clr_idx  = (32'(r_clr_idx) == scbpa_pkg::BLOCKS_PER_CLASS - 1) ?
                             '0 : r_clr_idx + 1'b1;
                if (32'(r_clr_addr) == scbpa_pkg::POOL_DEPTH - 1) begin
                    n_state = scbpa_pkg::BK_IDLE;
                end
            end
            scbpa_pkg::BK_IDLE: begin
                if (i_cmd_valid && !i_out_full) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        scbpa_pkg::OP_REPORT: begin
                            o_res_push        = 1'b1;
                            o_res.status      = i_cmd.status;
                            o_res.block_class = i_cmd.cls;
                            o_res.pool_slot   = i_cmd.idx;
                        end
                        scbpa_pkg::OP_ALLOC: begin
                            if (r_nonempty[i_cmd.cls]) begin
                                chosen     = i_cmd.cls;
                                have_class = 1'b1;
                            end else if (i_cmd.fb_ok && nonempty_up[i_cmd.cls]) begin
                                chosen     = i_cmd.cls + 1'b1;
                                have_class = 1'b1;
                            end
                            if (have_class) begin
                                n_op       = scbpa_pkg::OP_ALLOC;
                                n_cls      = chosen;
                                n_idx      = r_head[chosen];
                                link_raddr = scbpa_pkg::pool_addr(chosen, r_head[chosen]);
                                n_state    = scbpa_pkg::BK_ACCESS;
                            end else begin
                                o_res_push        = 1'b1;
                                o_res.status      = scbpa_pkg::ST_EXHAUST;
                                o_res.block_class = i_cmd.cls;
                            end
                        end
                        scbpa_pkg::OP_FREE: begin
                            n_op       = scbpa_pkg::OP_FREE;
                            n_cls      = i_cmd.cls;
                            n_idx      = i_cmd.idx;
                            used_raddr = scbpa_pkg::pool_addr(i_cmd.cls, i_cmd.idx);
                            n_state    = scbpa_pkg::BK_ACCESS;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            scbpa_pkg::BK_ACCESS: begin
                n_state           = scbpa_pkg::BK_IDLE;
                o_res_push        = 1'b1;
                o_res.block_class = r_cls;
                o_res.pool_slot   = r_idx;
                if (r_op == scbpa_pkg::OP_ALLOC) begin
                    cnt_new         = r_count[r_cls] - 1'b1;
                    used_we         = 1'b1;
                    used_waddr      = scbpa_pkg::pool_addr(r_cls, r_idx);
                    used_wdata      = 1'b1;
                    n_count[r_cls]  = cnt_new;
                    if (cnt_new != '0) begin
                        n_head[r_cls] = link_rdata;
                    end else begin
                        n_nonempty[r_cls] = 1'b0;
                    end
                    o_res.status    = scbpa_pkg::ST_ALLOC;
                    o_res.idle_left = cnt_new;
                end else if (!used_rdata[0]) begin
                    o_res.status    = scbpa_pkg::ST_DOUBLE;
                    o_res.idle_left = r_count[r_cls];
                end else begin
                    used_we    = 1'b1;
                    used_waddr = scbpa_pkg::pool_addr(r_cls, r_idx);
                    used_wdata = 1'b0;
                    // empty list: freed block becomes the head, else link it after the tail
                    if (r_count[r_cls] == '0) begin
                        n_head[r_cls] = r_idx;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = scbpa_pkg::pool_addr(r_cls, r_tail[r_cls]);
                        link_wdata = r_idx;
                    end
                    n_tail[r_cls] = r_idx;
                    cnt_new = (32'(r_count[r_cls]) < scbpa_pkg::BLOCKS_PER_CLASS) ?
                              r_count[r_cls] + 1'b1 : r_count[r_cls];
                    n_count[r_cls]    = cnt_new;
                    n_nonempty[r_cls] = 1'b1;
                    o_res.status      = scbpa_pkg::ST_FREED;
                    o_res.idle_left   = cnt_new;
                end
            end
            default: begin
                n_state = scbpa_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= scbpa_pkg::BK_CLEAR;
            r_clr_addr <= '0;
            r_clr_idx  <= '0;
            r_nonempty <= '1;
            r_op       <= scbpa_pkg::OP_REPORT;
            for (int c = 0; c < NC; c++) begin
                r_head[c]  <= '0;
                r_tail[c]  <= scbpa_pkg::IDX_W'(scbpa_pkg::BLOCKS_PER_CLASS - 1);
                r_count[c] <= scbpa_pkg::CNT_W'(scbpa_pkg::BLOCKS_PER_CLASS);
            end
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_clr_idx  <= n_clr_idx;
            r_nonempty <= n_nonempty;
            r_op       <= n_op;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls <= n_cls;
        r_idx <= n_idx;
    end

    a_access_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scbpa_pkg::BK_ACCESS) |=> (r_state == scbpa_pkg::BK_IDLE))
        else $error("pool engine stayed in access");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_out_full)
        else $error("result pushed into a full queue");

    a_alloc_from_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scbpa_pkg::BK_ACCESS && r_op == scbpa_pkg::OP_ALLOC)
        |-> (r_count[r_cls] != '0))
        else $error("allocation from an empty class");

    a_nonempty_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scbpa_pkg::BK_ACCESS)
        |-> (r_nonempty[r_cls] == (r_count[r_cls] != '0)))
        else $error("nonempty flag out of step with idle count");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scbpa_pkg::BK_ACCESS)
        |-> (32'(r_count[r_cls]) <= scbpa_pkg::BLOCKS_PER_CLASS))
        else $error("idle count above pool size");

endmodule

// ===== hdl/scbpa_out.sv =====
// two-entry result queue in front of the result port
module scbpa_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_push,
    input  scbpa_pkg::t_result i_res,
    output logic               o_q_full,
    output logic               o_empty,
    input  logic               i_pop,
    output scbpa_pkg::t_result o_res
);

    scbpa_pkg::t_result r_q [2];
    logic               r_wptr;
    logic               r_rptr;
    logic [1:0]         r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_q_full = (r_cnt == 2'd2);
    assign o_empty  = (r_cnt == 2'd0);
    assign do_push  = i_res_push && !o_q_full;
    assign do_pop   = i_pop && !o_empty;
    assign o_res    = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wptr] <= i_res;
        end
    end

endmodule
